// ----- rtl/core/gaee_pkg.sv -----
// Shared types and constants of the grid A* expansion engine.
package gaee_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_WALL    = 2'd0;
  localparam logic [1:0] KIND_EXPAND  = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // Search status codes.
  localparam logic [1:0] ST_SEARCH = 2'd0;
  localparam logic [1:0] ST_GOAL   = 2'd1;
  localparam logic [1:0] ST_NOPATH = 2'd2;

  // Heuristic modes; the fourth code behaves as octile.
  localparam logic [1:0] HM_OCTILE    = 2'd0;
  localparam logic [1:0] HM_MANHATTAN = 2'd1;
  localparam logic [1:0] HM_PENALTY   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_ROW = 3'd0;
  localparam logic [2:0] CFG_START_COL = 3'd1;
  localparam logic [2:0] CFG_GOAL_ROW  = 3'd2;
  localparam logic [2:0] CFG_GOAL_COL  = 3'd3;
  localparam logic [2:0] CFG_HEUR_MODE = 3'd4;

  localparam int unsigned COST_STRAIGHT = 10;
  localparam int unsigned COST_DIAG     = 14;
  localparam int unsigned PENALTY_DIAG  = 18;

  // One grid cell of search state.
  typedef struct packed {
    logic        explored;
    logic        frontier;
    logic [15:0] cost;
    logic [9:0]  heur;
    logic        pvalid;
    logic [7:0]  prow;
    logic [7:0]  pcol;
  } cell_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_all;
    logic clr_cell;
    logic cnt_clr;
    logic cnt_inc;
    logic ld_item;
    logic wall_wr;
    logic rd_item;
    logic cap_read;
    logic rd_cur;
    logic wr_cur;
    logic rd_nb;
    logic wr_nb;
    logic rd_goal;
    logic wr_goal;
    logic set_nopath;
    logic start;
    logic scan_init;
    logic scan_rd;
    logic scan_cmp;
    logic scan_fin;
    logic out_ld;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_last;
    logic       nb_last;
    logic       cnt_zero;
    logic       searching;
    logic       cur_in_grid;
    logic       goal_adj;
    logic       out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/gaee_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
interface gaee_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] cell_row;
  logic [5:0] cell_col;
  logic       wall_bit;

  modport source (output valid, kind, cell_row, cell_col, wall_bit, input ready);
  modport sink (input valid, kind, cell_row, cell_col, wall_bit, output ready);
endinterface

interface gaee_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  current_row_out;
  logic [5:0]  current_col_out;
  logic [15:0] read_cost;
  logic [16:0] read_total;
  logic [5:0]  read_parent_row;
  logic [5:0]  read_parent_col;
  logic        read_has_parent;
  logic        read_explored;
  logic        read_frontier;

  modport source (output valid, status, current_row_out, current_col_out, read_cost,
                  read_total, read_parent_row, read_parent_col, read_has_parent,
                  read_explored, read_frontier, input ready);
  modport sink (input valid, status, current_row_out, current_col_out, read_cost,
                read_total, read_parent_row, read_parent_col, read_has_parent,
                read_explored, read_frontier, output ready);
endinterface

// ----- rtl/core/gaee_ctrl.sv -----
// Sequencing state machine of the grid A* expansion engine.
module gaee_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gaee_pkg::dp_stat_t  stat_i,
  output gaee_pkg::ctrl_cmd_t cmd_o
);
  import gaee_pkg::*;

  typedef enum logic [14:0] {
    S_CLR_ALL  = 15'h0001,
    S_IDLE     = 15'h0002,
    S_DISPATCH = 15'h0004,
    S_RD_DATA  = 15'h0008,
    S_CLR_CELL = 15'h0010,
    S_START    = 15'h0020,
    S_WR_CUR   = 15'h0040,
    S_NB_RD    = 15'h0080,
    S_NB_WR    = 15'h0100,
    S_GOAL_CHK = 15'h0200,
    S_GOAL_WR  = 15'h0400,
    S_SCAN     = 15'h0800,
    S_SCAN_END = 15'h1000,
    S_SCAN_FIN = 15'h2000,
    S_RESP     = 15'h4000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR_ALL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR_ALL: begin
        cmd_o.clr_all = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.kind)
          KIND_WALL: begin
            cmd_o.wall_wr = 1'b1;
            state_d = S_RESP;
          end
          KIND_READ: begin
            cmd_o.rd_item = 1'b1;
            state_d = S_RD_DATA;
          end
          KIND_RESTART: begin
            cmd_o.cnt_clr = 1'b1;
            state_d = S_CLR_CELL;
          end
          default: begin
            if (!stat_i.searching) begin
              state_d = S_RESP;
            end else if (!stat_i.cur_in_grid) begin
              cmd_o.set_nopath = 1'b1;
              state_d = S_RESP;
            end else begin
              cmd_o.rd_cur = 1'b1;
              state_d = S_WR_CUR;
            end
          end
        endcase
      end
      S_RD_DATA: begin
        cmd_o.cap_read = 1'b1;
        state_d = S_RESP;
      end
      S_CLR_CELL: begin
        cmd_o.clr_cell = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_START;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d = S_RESP;
      end
      S_WR_CUR: begin
        cmd_o.wr_cur  = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d = S_NB_RD;
      end
      S_NB_RD: begin
        cmd_o.rd_nb = 1'b1;
        state_d = S_NB_WR;
      end
      S_NB_WR: begin
        cmd_o.wr_nb = 1'b1;
        if (stat_i.nb_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_GOAL_CHK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_NB_RD;
        end
      end
      S_GOAL_CHK: begin
        if (stat_i.goal_adj) begin
          cmd_o.rd_goal = 1'b1;
          state_d = S_GOAL_WR;
        end else begin
          cmd_o.scan_init = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_GOAL_WR: begin
        cmd_o.wr_goal = 1'b1;
        state_d = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan_rd  = 1'b1;
        cmd_o.scan_cmp = !stat_i.cnt_zero;
        if (stat_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_SCAN_END;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_SCAN_END: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = S_SCAN_FIN;
      end
      S_SCAN_FIN: begin
        cmd_o.scan_fin = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/gaee_dp.sv -----
// Datapath of the grid A* expansion engine: cell memories, counters, arithmetic, result.
module gaee_dp #(
  parameter int unsigned GRID_ROWS = 64,
  parameter int unsigned GRID_COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [5:0]          cfg_data_i,
  input  logic [1:0]          kind_i,
  input  logic [5:0]          cell_row_i,
  input  logic [5:0]          cell_col_i,
  input  logic                wall_bit_i,
  input  gaee_pkg::ctrl_cmd_t cmd_i,
  output gaee_pkg::dp_stat_t  stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          status_o,
  output logic [5:0]          current_row_out_o,
  output logic [5:0]          current_col_out_o,
  output logic [15:0]         read_cost_o,
  output logic [16:0]         read_total_o,
  output logic [5:0]          read_parent_row_o,
  output logic [5:0]          read_parent_col_o,
  output logic                read_has_parent_o,
  output logic                read_explored_o,
  output logic                read_frontier_o
);
  import gaee_pkg::*;

  localparam int unsigned CELLS = GRID_ROWS * GRID_COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(GRID_ROWS);
  localparam int unsigned CLW   = $clog2(GRID_COLS);
  localparam int unsigned CRW   = (RW > 6) ? RW : 6;
  localparam int unsigned CCW   = (CLW > 6) ? CLW : 6;

  // Storage.
  cell_t cell_mem [CELLS];
  logic  wall_mem [CELLS];
  cell_t rdata_q;
  logic  wall_q;

  // Configuration.
  logic [5:0] start_row_q, start_col_q, goal_row_q, goal_col_q;
  logic [1:0] hmode_q;

  // Search registers.
  logic [CRW-1:0] cur_row_q;
  logic [CCW-1:0] cur_col_q;
  logic [1:0]     status_q;
  logic [15:0]    ccost_q;
  logic [AW-1:0]  cnt_q;

  // Latched item.
  logic [1:0] kind_q;
  logic [5:0] item_row_q, item_col_q;
  logic       item_wall_q;

  // Scan registers.
  logic [CRW-1:0] sr_q, rd_r_q, bi_r_q;
  logic [CCW-1:0] sc_q, rd_c_q, bi_c_q;
  logic           found_q;
  logic [16:0]    best_q;

  // Captured read fields and result register.
  cell_t rf_q;
  logic  out_valid_q;

  function automatic logic [AW-1:0] addr_of(input logic [CRW-1:0] r,
                                            input logic [CCW-1:0] c);
    return AW'(r) * AW'(GRID_COLS) + AW'(c);
  endfunction

  function automatic logic [9:0] heur_of(input logic [5:0] gr, input logic [5:0] gc,
                                         input logic [1:0] mode, input logic [CRW-1:0] r,
                                         input logic [CCW-1:0] c, input logic diag);
    logic [8:0]  a, b, dr, dc, lo, hi;
    logic [11:0] h;
    a  = 9'(gr);
    b  = 9'(r);
    dr = (a > b) ? a - b : b - a;
    a  = 9'(gc);
    b  = 9'(c);
    dc = (a > b) ? a - b : b - a;
    lo = (dr < dc) ? dr : dc;
    hi = (dr < dc) ? dc : dr;
    h  = 12'(lo) * 12'(COST_DIAG) + 12'(hi - lo) * 12'(COST_STRAIGHT);
    case (mode)
      HM_MANHATTAN: h = 12'(dr) + 12'(dc);
      HM_PENALTY:   h = h + (diag ? 12'(PENALTY_DIAG) : 12'(COST_STRAIGHT));
      default:      h = h;
    endcase
    return h[9:0];
  endfunction

  // Neighbour offsets in row-major order over the 3x3 window.
  logic [1:0] dr_off, dc_off;
  always_comb begin
    case (cnt_q[3:0])
      4'd0: begin dr_off = 2'd0; dc_off = 2'd0; end
      4'd1: begin dr_off = 2'd0; dc_off = 2'd1; end
      4'd2: begin dr_off = 2'd0; dc_off = 2'd2; end
      4'd3: begin dr_off = 2'd1; dc_off = 2'd0; end
      4'd4: begin dr_off = 2'd1; dc_off = 2'd1; end
      4'd5: begin dr_off = 2'd1; dc_off = 2'd2; end
      4'd6: begin dr_off = 2'd2; dc_off = 2'd0; end
      4'd7: begin dr_off = 2'd2; dc_off = 2'd1; end
      default: begin dr_off = 2'd2; dc_off = 2'd2; end
    endcase
  end

  logic [CRW:0]   nrp;
  logic [CCW:0]   ncp;
  logic [CRW-1:0] nb_row;
  logic [CCW-1:0] nb_col;
  logic           nb_ok, diag;
  logic [16:0]    cand_w;
  logic [15:0]    cand;
  logic [9:0]     nb_heur;
  cell_t          nb_new;

  assign nrp    = (CRW + 1)'(cur_row_q) + (CRW + 1)'(dr_off);
  assign ncp    = (CCW + 1)'(cur_col_q) + (CCW + 1)'(dc_off);
  assign nb_row = CRW'(nrp - 1'b1);
  assign nb_col = CCW'(ncp - 1'b1);
  assign nb_ok  = (nrp != '0) && (ncp != '0) && (int'(nb_row) < int'(GRID_ROWS))
               && (int'(nb_col) < int'(GRID_COLS)) && (int'(nrp) <= int'(GRID_ROWS))
               && (int'(ncp) <= int'(GRID_COLS));
  assign diag   = (dr_off != 2'd1) && (dc_off != 2'd1);
  assign cand_w = 17'(ccost_q) + (diag ? 17'(COST_DIAG) : 17'(COST_STRAIGHT));
  assign cand   = cand_w[16] ? 16'hFFFF : cand_w[15:0];
  assign nb_heur = heur_of(goal_row_q, goal_col_q, hmode_q, nb_row, nb_col, diag);

  always_comb begin
    nb_new = rdata_q;
    nb_new.frontier = 1'b1;
    if (rdata_q.cost != '0) begin
      if (rdata_q.cost > cand) begin
        nb_new.cost   = cand;
        nb_new.pvalid = 1'b1;
        nb_new.prow   = 8'(cur_row_q);
        nb_new.pcol   = 8'(cur_col_q);
      end
    end else begin
      nb_new.cost   = cand;
      nb_new.heur   = nb_heur;
      nb_new.pvalid = 1'b1;
      nb_new.prow   = 8'(cur_row_q);
      nb_new.pcol   = 8'(cur_col_q);
    end
  end

  // Grid and goal checks.
  logic item_in_grid, cur_in_grid, start_in_grid, goal_in_grid, goal_adj;
  logic [6:0] gdr, gdc;
  assign item_in_grid  = (int'(item_row_q) < int'(GRID_ROWS))
                      && (int'(item_col_q) < int'(GRID_COLS));
  assign cur_in_grid   = (int'(cur_row_q) < int'(GRID_ROWS))
                      && (int'(cur_col_q) < int'(GRID_COLS));
  assign start_in_grid = (int'(start_row_q) < int'(GRID_ROWS))
                      && (int'(start_col_q) < int'(GRID_COLS));
  assign goal_in_grid  = (int'(goal_row_q) < int'(GRID_ROWS))
                      && (int'(goal_col_q) < int'(GRID_COLS));
  assign gdr = (7'(goal_row_q) > 7'(cur_row_q)) ? 7'(goal_row_q) - 7'(cur_row_q)
                                                : 7'(cur_row_q) - 7'(goal_row_q);
  assign gdc = (7'(goal_col_q) > 7'(cur_col_q)) ? 7'(goal_col_q) - 7'(cur_col_q)
                                                : 7'(cur_col_q) - 7'(goal_col_q);
  assign goal_adj = goal_in_grid && cur_in_grid && (gdr <= 7'd1) && (gdc <= 7'd1);

  // Memory port selection.
  logic [AW-1:0] item_addr, cur_addr, goal_addr, nb_addr, start_addr;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en, wall_we;
  logic          wall_d;
  cell_t         wr_data;

  assign item_addr  = addr_of(CRW'(item_row_q), CCW'(item_col_q));
  assign cur_addr   = addr_of(cur_row_q, cur_col_q);
  assign goal_addr  = addr_of(CRW'(goal_row_q), CCW'(goal_col_q));
  assign nb_addr    = addr_of(nb_row, nb_col);
  assign start_addr = addr_of(CRW'(start_row_q), CCW'(start_col_q));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_addr;
    if (cmd_i.rd_item) begin
      rd_en = item_in_grid; rd_addr = item_addr;
    end else if (cmd_i.rd_cur) begin
      rd_en = 1'b1;
    end else if (cmd_i.rd_nb) begin
      rd_en = nb_ok; rd_addr = nb_addr;
    end else if (cmd_i.rd_goal) begin
      rd_en = 1'b1; rd_addr = goal_addr;
    end else if (cmd_i.scan_rd) begin
      rd_en = 1'b1; rd_addr = cnt_q;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q;
    wr_data = '0;
    wall_we = 1'b0;
    wall_d  = 1'b0;
    if (cmd_i.clr_all) begin
      wr_en = 1'b1; wall_we = 1'b1;
    end else if (cmd_i.clr_cell) begin
      wr_en = 1'b1;
    end else if (cmd_i.wall_wr) begin
      wall_we = item_in_grid; wr_addr = item_addr; wall_d = item_wall_q;
    end else if (cmd_i.start) begin
      wr_en = start_in_grid; wr_addr = start_addr;
      wr_data.explored = 1'b1;
    end else if (cmd_i.wr_cur) begin
      wr_en = 1'b1; wr_addr = cur_addr;
      wr_data = rdata_q;
      wr_data.explored = 1'b1;
    end else if (cmd_i.wr_nb) begin
      wr_en = nb_ok && !wall_q && !rdata_q.explored; wr_addr = nb_addr;
      wr_data = nb_new;
    end else if (cmd_i.wr_goal) begin
      wr_en = 1'b1; wr_addr = goal_addr;
      wr_data = rdata_q;
      wr_data.pvalid = 1'b1;
      wr_data.prow   = 8'(cur_row_q);
      wr_data.pcol   = 8'(cur_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    if (wall_we) begin
      wall_mem[wr_addr] <= wall_d;
    end
    if (rd_en) begin
      rdata_q <= cell_mem[rd_addr];
      wall_q  <= wall_mem[rd_addr];
    end
  end

  // Scan comparison.
  logic [16:0] rd_total;
  logic        better;
  assign rd_total = 17'(rdata_q.cost) + 17'(rdata_q.heur);
  assign better   = rdata_q.frontier && !rdata_q.explored && (!found_q || rd_total < best_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_row_q <= 6'd1;
      start_col_q <= 6'd1;
      goal_row_q  <= 6'd62;
      goal_col_q  <= 6'd62;
      hmode_q     <= HM_OCTILE;
      cur_row_q   <= CRW'(1);
      cur_col_q   <= CCW'(1);
      status_q    <= ST_SEARCH;
      cnt_q       <= '0;
      sr_q        <= '0;
      sc_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_ROW: start_row_q <= cfg_data_i;
          CFG_START_COL: start_col_q <= cfg_data_i;
          CFG_GOAL_ROW:  goal_row_q  <= cfg_data_i;
          CFG_GOAL_COL:  goal_col_q  <= cfg_data_i;
          CFG_HEUR_MODE: hmode_q     <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
        sr_q  <= '0;
        sc_q  <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
        if (cmd_i.scan_rd) begin
          if (int'(sc_q) == int'(GRID_COLS) - 1) begin
            sc_q <= '0;
            sr_q <= sr_q + 1'b1;
          end else begin
            sc_q <= sc_q + 1'b1;
          end
        end
      end
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_cmp && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.set_nopath) begin
        status_q <= ST_NOPATH;
      end
      if (cmd_i.start) begin
        cur_row_q <= CRW'(start_row_q);
        cur_col_q <= CCW'(start_col_q);
        status_q  <= ST_SEARCH;
      end
      if (cmd_i.wr_goal) begin
        cur_row_q <= CRW'(goal_row_q);
        cur_col_q <= CCW'(goal_col_q);
        status_q  <= ST_GOAL;
      end
      if (cmd_i.scan_fin) begin
        if (found_q) begin
          cur_row_q <= bi_r_q;
          cur_col_q <= bi_c_q;
        end else begin
          status_q <= ST_NOPATH;
        end
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      kind_q      <= kind_i;
      item_row_q  <= cell_row_i;
      item_col_q  <= cell_col_i;
      item_wall_q <= wall_bit_i;
      rf_q        <= '0;
    end
    if (cmd_i.cap_read && item_in_grid) begin
      rf_q <= rdata_q;
    end
    if (cmd_i.wr_cur) begin
      ccost_q <= rdata_q.cost;
    end
    if (cmd_i.scan_rd) begin
      rd_r_q <= sr_q;
      rd_c_q <= sc_q;
    end
    if (cmd_i.scan_cmp && better) begin
      best_q <= rd_total;
      bi_r_q <= rd_r_q;
      bi_c_q <= rd_c_q;
    end
    if (cmd_i.out_ld) begin
      status_o          <= status_q;
      current_row_out_o <= cur_row_q[5:0];
      current_col_out_o <= cur_col_q[5:0];
      read_cost_o       <= rf_q.cost;
      read_total_o      <= 17'(rf_q.cost) + 17'(rf_q.heur);
      read_parent_row_o <= rf_q.prow[5:0];
      read_parent_col_o <= rf_q.pcol[5:0];
      read_has_parent_o <= rf_q.pvalid;
      read_explored_o   <= rf_q.explored;
      read_frontier_o   <= rf_q.frontier;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.kind        = kind_q;
  assign stat_o.cnt_last    = (int'(cnt_q) == int'(CELLS) - 1);
  assign stat_o.nb_last     = (cnt_q == AW'(8));
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.searching   = (status_q == ST_SEARCH);
  assign stat_o.cur_in_grid = cur_in_grid;
  assign stat_o.goal_adj    = goal_adj;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/core/grid_astar_expansion_engine_unit.sv -----
// Top level of the grid A* expansion engine: controller, datapath and channel glue.
// Items are taken one at a time: wall write, cell read, restart (one cell cleared a cycle),
// or expansion: a pass over the neighbours, then either the goal beside the cell is linked or
// every cell is read through the single read port of the cell memory to find the minimum.
// A stalled result adds its wait.
// After reset every cell memory is cleared before the first beat.
module grid_astar_expansion_engine_unit #(
  parameter int unsigned GRID_ROWS = 64,
  parameter int unsigned GRID_COLS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  gaee_in_if.sink    in_ch,
  gaee_out_if.source out_ch
);
  import gaee_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // The controller walks one item at a time through its sequence of memory
  // accesses; the datapath owns the memories, counters and the result register,
  // so a finished result can wait on the output while the next beat is taken.
  gaee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gaee_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (in_ch.kind),
    .cell_row_i        (in_ch.cell_row),
    .cell_col_i        (in_ch.cell_col),
    .wall_bit_i        (in_ch.wall_bit),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .status_o          (out_ch.status),
    .current_row_out_o (out_ch.current_row_out),
    .current_col_out_o (out_ch.current_col_out),
    .read_cost_o       (out_ch.read_cost),
    .read_total_o      (out_ch.read_total),
    .read_parent_row_o (out_ch.read_parent_row),
    .read_parent_col_o (out_ch.read_parent_col),
    .read_has_parent_o (out_ch.read_has_parent),
    .read_explored_o   (out_ch.read_explored),
    .read_frontier_o   (out_ch.read_frontier)
  );

  assign in_ch.ready = in_ready;

endmodule

// ----- bench/tb_grid_astar_expansion_engine_unit.sv -----
// Self-checking testbench of the grid A* expansion engine with its own search predictor.
module tb_grid_astar_expansion_engine_unit;
  import gaee_pkg::*;

  // The grid size of the instance; the predictor uses the same figures.
  localparam int Rows = 64;
  localparam int Cols = 64;
  localparam int Cells = Rows * Cols;
  // A beat must move on some channel within this many cycles. The slowest
  // item is an expansion or a restart, each of which passes over every cell; the
  // clearing pass after reset is as long, and the long hold-off adds its wait.
  localparam int WatchLimit = 30000;
  localparam int HoldOffCycles = 400;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  cur_row;
    logic [5:0]  cur_col;
    logic [15:0] cost;
    logic [16:0] total;
    logic [5:0]  par_row;
    logic [5:0]  par_col;
    logic        has_par;
    logic        explored;
    logic        frontier;
  } search_res_t;

  // One row of the directed table. When at_reset is set, the expected beat is
  // the plain state after reset: searching, current cell (1,1), read fields zero.
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic       wall;
    logic       at_reset;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [5:0] cfg_data_i;

  gaee_in_if in_ch ();
  gaee_out_if out_ch ();

  grid_astar_expansion_engine_unit i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Predictor state: the configuration, the cell stores and the search position.
  logic [5:0] start_row_q, start_col_q, goal_row_q, goal_col_q;
  logic [1:0] heur_mode_q;
  bit         wall_m [Cells];
  bit         explored_m [Cells];
  bit         frontier_m [Cells];
  logic [15:0] cost_m [Cells];
  logic [9:0]  heur_m [Cells];
  logic [16:0] total_m [Cells];
  bit          pvalid_m [Cells];
  logic [5:0]  prow_m [Cells];
  logic [5:0]  pcol_m [Cells];
  logic [5:0]  cur_row_q, cur_col_q;
  logic [1:0]  status_q;

  search_res_t expected_beats[$];
  int          error_count;
  bit          hold_off_req;
  bit          beat_moved;

  always #6 clk_i = ~clk_i;

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Distance estimate to the goal; the fourth mode code behaves as octile.
  function automatic int goal_estimate(int r, int c, bit diag);
    int dr, dc, lo, hi, h;
    dr = abs_diff(goal_row_q, r);
    dc = abs_diff(goal_col_q, c);
    lo = (dr < dc) ? dr : dc;
    hi = (dr < dc) ? dc : dr;
    if (heur_mode_q == HM_MANHATTAN) begin
      return dr + dc;
    end
    h = lo * COST_DIAG + (hi - lo) * COST_STRAIGHT;
    if (heur_mode_q == HM_PENALTY) begin
      h += diag ? PENALTY_DIAG : COST_STRAIGHT;
    end
    return h;
  endfunction

  // Clears the search stores, keeping the walls, and places the search at the start.
  function automatic void clear_search();
    for (int k = 0; k < Cells; k++) begin
      explored_m[k] = 0;
      frontier_m[k] = 0;
      cost_m[k] = '0;
      heur_m[k] = '0;
      total_m[k] = '0;
      pvalid_m[k] = 0;
      prow_m[k] = '0;
      pcol_m[k] = '0;
    end
    cur_row_q = start_row_q;
    cur_col_q = start_col_q;
    status_q = ST_SEARCH;
  endfunction

  // One expansion step of the current cell, then selection of the next one.
  function automatic void expand_search();
    int cr, cc, ck, k, cand, best, bi;
    bit diag, found;
    cr = cur_row_q;
    cc = cur_col_q;
    ck = cr * Cols + cc;
    found = 0;
    best = 0;
    bi = 0;
    explored_m[ck] = 1;
    for (int r = (cr > 0 ? cr - 1 : 0); r <= (cr + 1 < Rows ? cr + 1 : cr); r++) begin
      for (int c = (cc > 0 ? cc - 1 : 0); c <= (cc + 1 < Cols ? cc + 1 : cc); c++) begin
        k = r * Cols + c;
        diag = (r != cr) && (c != cc);
        if (!wall_m[k] && !explored_m[k]) begin
          frontier_m[k] = 1;
          cand = cost_m[ck] + (diag ? COST_DIAG : COST_STRAIGHT);
          if (cand > 65535) cand = 65535;
          if (cost_m[k] != 0) begin
            if (cost_m[k] > cand) begin
              cost_m[k] = cand[15:0];
              pvalid_m[k] = 1;
              prow_m[k] = cr[5:0];
              pcol_m[k] = cc[5:0];
            end
          end else begin
            cost_m[k] = cand[15:0];
            heur_m[k] = 10'(goal_estimate(r, c, diag));
            pvalid_m[k] = 1;
            prow_m[k] = cr[5:0];
            pcol_m[k] = cc[5:0];
          end
          total_m[k] = heur_m[k] + cost_m[k];
        end
      end
    end
    // A goal next to (or on) the expanded cell ends the search there.
    if (abs_diff(goal_row_q, cr) <= 1 && abs_diff(goal_col_q, cc) <= 1) begin
      k = goal_row_q * Cols + goal_col_q;
      pvalid_m[k] = 1;
      prow_m[k] = cr[5:0];
      pcol_m[k] = cc[5:0];
      status_q = ST_GOAL;
      cur_row_q = goal_row_q;
      cur_col_q = goal_col_q;
      return;
    end
    for (int j = 0; j < Cells; j++) begin
      if (frontier_m[j] && !explored_m[j] && (!found || total_m[j] < best)) begin
        found = 1;
        best = total_m[j];
        bi = j;
      end
    end
    if (!found) begin
      status_q = ST_NOPATH;
      return;
    end
    cur_row_q = 6'(bi / Cols);
    cur_col_q = 6'(bi % Cols);
  endfunction

  // Applies one accepted item to the predictor and returns the beat it causes.
  function automatic search_res_t search_step(logic [1:0] kind, logic [5:0] r, logic [5:0] c,
                                             logic w);
    search_res_t res;
    int k;
    res = '0;
    k = r * Cols + c;
    case (kind)
      KIND_WALL: begin
        wall_m[k] = w;
      end
      KIND_EXPAND: begin
        if (status_q == ST_SEARCH) expand_search();
      end
      KIND_RESTART: begin
        clear_search();
        explored_m[cur_row_q * Cols + cur_col_q] = 1;
      end
      default: begin
        res.cost = cost_m[k];
        res.total = total_m[k];
        res.par_row = prow_m[k];
        res.par_col = pcol_m[k];
        res.has_par = pvalid_m[k];
        res.explored = explored_m[k];
        res.frontier = frontier_m[k];
      end
    endcase
    res.status = status_q;
    res.cur_row = cur_row_q;
    res.cur_col = cur_col_q;
    return res;
  endfunction

  // Offers one item after a random gap and records its expected beat on acceptance.
  task automatic send_item(logic [1:0] kind, logic [5:0] r, logic [5:0] c, logic w,
                           bit at_reset);
    int gap;
    search_res_t res;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.cell_row <= r;
    in_ch.cell_col <= c;
    in_ch.wall_bit <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    res = search_step(kind, r, c, w);
    if (at_reset) begin
      res = '0;
      res.status = ST_SEARCH;
      res.cur_row = 6'd1;
      res.cur_col = 6'd1;
    end
    expected_beats.push_back(res);
  endtask

  // Lowers valid and waits until every expected beat has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes one register; the enable drops after the clock edge that takes the write, so writes never share a time step.
  task automatic write_reg(logic [2:0] idx, logic [5:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_START_ROW: start_row_q = value;
      CFG_START_COL: start_col_q = value;
      CFG_GOAL_ROW:  goal_row_q = value;
      CFG_GOAL_COL:  goal_col_q = value;
      default:       heur_mode_q = value[1:0];
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [5:0] near(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v[5:0];
  endfunction

  // One phase of random stimulus around the current search position.
  task automatic search_phase(int items);
    int pick;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_item(KIND_EXPAND, 6'($urandom), 6'($urandom), 1'($urandom), 0);
      end else if (pick < 75) begin
        send_item(KIND_READ, near(int'(cur_row_q), 2), near(int'(cur_col_q), 2),
                  1'($urandom), 0);
      end else if (pick < 88) begin
        send_item(KIND_WALL, near(int'(cur_row_q), 2), near(int'(cur_col_q), 2),
                  1'($urandom), 0);
      end else if (pick < 95) begin
        send_item(KIND_READ, 6'($urandom), 6'($urandom), 1'($urandom), 0);
      end else begin
        send_item(KIND_RESTART, 6'($urandom), 6'($urandom), 1'($urandom), 0);
      end
    end
  endtask

  // The receiving side: a random stall before each beat, or the long hold-off when asked.
  always begin
    int stall;
    search_res_t got, want;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        stall = HoldOffCycles;
        hold_off_req = 0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got = '{out_ch.status, out_ch.current_row_out, out_ch.current_col_out,
              out_ch.read_cost, out_ch.read_total, out_ch.read_parent_row,
              out_ch.read_parent_col, out_ch.read_has_parent, out_ch.read_explored,
              out_ch.read_frontier};
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %p", $time, got);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        if (got.cur_row !== want.cur_row)
          $display("%0t: current_row expected %0d got %0d", $time, want.cur_row, got.cur_row);
        if (got.cur_col !== want.cur_col)
          $display("%0t: current_col expected %0d got %0d", $time, want.cur_col, got.cur_col);
        if (got.cost !== want.cost)
          $display("%0t: read_cost expected %0d got %0d", $time, want.cost, got.cost);
        if (got.total !== want.total)
          $display("%0t: read_total expected %0d got %0d", $time, want.total, got.total);
        if (got.par_row !== want.par_row)
          $display("%0t: parent_row expected %0d got %0d", $time, want.par_row, got.par_row);
        if (got.par_col !== want.par_col)
          $display("%0t: parent_col expected %0d got %0d", $time, want.par_col, got.par_col);
        if (got.has_par !== want.has_par)
          $display("%0t: has_parent expected %0d got %0d", $time, want.has_par, got.has_par);
        if (got.explored !== want.explored)
          $display("%0t: explored expected %0d got %0d", $time, want.explored, got.explored);
        if (got.frontier !== want.frontier)
          $display("%0t: frontier expected %0d got %0d", $time, want.frontier, got.frontier);
        if (got !== want) error_count++;
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    int idle_cycles;
    beat_moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
    if (!rst_ni || beat_moved) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Directed rows: extremes of every field, each kind, walls beside the start,
  // expansion, reads of reached and wall cells, and two restarts.
  directed_row_t directed_rows[] = '{
    '{KIND_READ, 6'd0, 6'd0, 1'b0, 1'b1},
    '{KIND_READ, 6'd63, 6'd63, 1'b1, 1'b1},
    '{KIND_WALL, 6'd0, 6'd0, 1'b1, 1'b1},
    '{KIND_WALL, 6'd63, 6'd63, 1'b1, 1'b1},
    '{KIND_WALL, 6'd63, 6'd0, 1'b0, 1'b1},
    '{KIND_WALL, 6'd0, 6'd63, 1'b1, 1'b1},
    '{KIND_WALL, 6'd2, 6'd2, 1'b1, 1'b1},
    '{KIND_WALL, 6'd42, 6'd21, 1'b1, 1'b1},
    '{KIND_READ, 6'd0, 6'd0, 1'b0, 1'b0},
    '{KIND_EXPAND, 6'd0, 6'd0, 1'b0, 1'b0},
    '{KIND_READ, 6'd1, 6'd1, 1'b0, 1'b0},
    '{KIND_READ, 6'd1, 6'd2, 1'b0, 1'b0},
    '{KIND_READ, 6'd2, 6'd2, 1'b0, 1'b0},
    '{KIND_READ, 6'd0, 6'd0, 1'b0, 1'b0},
    '{KIND_EXPAND, 6'd63, 6'd63, 1'b1, 1'b0},
    '{KIND_EXPAND, 6'd21, 6'd42, 1'b0, 1'b0},
    '{KIND_READ, 6'd2, 6'd1, 1'b0, 1'b0},
    '{KIND_RESTART, 6'd0, 6'd0, 1'b0, 1'b0},
    '{KIND_READ, 6'd1, 6'd1, 1'b0, 1'b0},
    '{KIND_WALL, 6'd2, 6'd2, 1'b0, 1'b0},
    '{KIND_EXPAND, 6'd0, 6'd0, 1'b0, 1'b0},
    '{KIND_READ, 6'd2, 6'd2, 1'b0, 1'b0},
    '{KIND_RESTART, 6'd63, 6'd63, 1'b1, 1'b0}
  };

  initial begin
    logic [5:0] sr, sc;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_START_ROW;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WALL;
    in_ch.cell_row = '0;
    in_ch.cell_col = '0;
    in_ch.wall_bit = 1'b0;
    out_ch.ready = 1'b0;
    error_count = 0;
    hold_off_req = 0;
    start_row_q = 6'd1;
    start_col_q = 6'd1;
    goal_row_q = 6'd62;
    goal_col_q = 6'd62;
    heur_mode_q = HM_OCTILE;
    for (int k = 0; k < Cells; k++) wall_m[k] = 0;
    clear_search();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].row, directed_rows[i].col,
                directed_rows[i].wall, directed_rows[i].at_reset);
    end
    drain_results();

    // Phases with different settings: corner starts in both directions, a goal
    // two cells away, the goal on the start, a walled-in start with no path,
    // and a mid-grid search under the penalty heuristic.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin write_reg(CFG_START_ROW, 6'd0); write_reg(CFG_START_COL, 6'd0);
                 write_reg(CFG_GOAL_ROW, 6'd63); write_reg(CFG_GOAL_COL, 6'd63);
                 write_reg(CFG_HEUR_MODE, HM_OCTILE); end
        1: begin write_reg(CFG_START_ROW, 6'd63); write_reg(CFG_START_COL, 6'd63);
                 write_reg(CFG_GOAL_ROW, 6'd0); write_reg(CFG_GOAL_COL, 6'd0);
                 write_reg(CFG_HEUR_MODE, HM_MANHATTAN); end
        2: begin write_reg(CFG_START_ROW, 6'd10); write_reg(CFG_START_COL, 6'd10);
                 write_reg(CFG_GOAL_ROW, 6'd12); write_reg(CFG_GOAL_COL, 6'd11);
                 write_reg(CFG_HEUR_MODE, HM_PENALTY); end
        3: begin write_reg(CFG_START_ROW, 6'd5); write_reg(CFG_START_COL, 6'd5);
                 write_reg(CFG_GOAL_ROW, 6'd5); write_reg(CFG_GOAL_COL, 6'd5);
                 write_reg(CFG_HEUR_MODE, 2'd3); end
        4: begin write_reg(CFG_START_ROW, 6'd20); write_reg(CFG_START_COL, 6'd20);
                 write_reg(CFG_GOAL_ROW, 6'd40); write_reg(CFG_GOAL_COL, 6'd40);
                 write_reg(CFG_HEUR_MODE, HM_OCTILE); end
        default: begin
                 write_reg(CFG_START_ROW, 6'($urandom_range(8, 55)));
                 write_reg(CFG_START_COL, 6'($urandom_range(8, 55)));
                 write_reg(CFG_GOAL_ROW, 6'($urandom));
                 write_reg(CFG_GOAL_COL, 6'($urandom));
                 write_reg(CFG_HEUR_MODE, HM_PENALTY); end
      endcase
      sr = start_row_q;
      sc = start_col_q;
      // In the second phase the receiver holds off while the short wall items keep coming.
      if (p == 1) hold_off_req = 1;
      // Clear walls around the start so the search goes; the no-path phase walls it in.
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          send_item(KIND_WALL, near(int'(sr) + dr, 0), near(int'(sc) + dc, 0),
                    p == 4 && (dr != 0 || dc != 0), 0);
        end
      end
      send_item(KIND_RESTART, 6'($urandom), 6'($urandom), 1'($urandom), 0);
      search_phase(p == 4 ? 6 : 11);
      drain_results();
    end

    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
